### hdl/tcct_pkg.sv
// ----------------------------------------------------------------------------
// tcct_pkg: shared types and constants of the connection cookie tracker
// Entry layout, table geometry and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tcct_pkg;

   // Table depth. Must be a power of two in 256..65536; the slot is the
   // low bits of the connection id.
   localparam int TABLE_ENTRIES = 65536;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int ID_W     = 16;
   localparam int ADDR_W   = 32;
   localparam int HALF_W   = 16;
   localparam int PROTO_W  = 8;
   localparam int PORT_W   = 16;
   localparam int COOKIE_W = 16;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [ID_W-1:0]     id_type;
   typedef logic [COOKIE_W-1:0] cookie_type;

   typedef struct packed {
      logic       active;
      logic       closing;
      cookie_type cookie;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '{active: 1'b0, closing: 1'b0, cookie: '0};

   // Controller -> datapath
   typedef struct packed {
      logic clr_write;   // write one zero entry of the clearing sweep
      logic load_req;    // capture the accepted request beat
      logic load_id;     // register the connection id
      logic mem_read;    // read the table entry at the id's slot
      logic commit;      // write back the entry and load the result register
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clr_last;    // sweep counter sits on the last entry
      logic out_busy;    // result register full and not taken this cycle
   } ctrl_stat_type;

endpackage

### hdl/tcct_ctrl.sv
// ----------------------------------------------------------------------------
// tcct_ctrl: sequencer of the connection cookie tracker
// Runs the clearing sweep after reset, then steps each request through
// capture, id, table read and write-back.
// ----------------------------------------------------------------------------
module tcct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tcct_pkg::ctrl_stat_type stat,
   output tcct_pkg::ctrl_cmd_type  cmd
);
   import tcct_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_UPDATE
   } state_type;

   state_type state_ff;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR:  cmd.clr_write = 1'b1;
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_HASH:   cmd.load_id  = 1'b1;
         S_READ:   cmd.mem_read = 1'b1;
         S_UPDATE: cmd.commit   = !stat.out_busy;
         default:  cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR:  if (stat.clr_last) state_ff <= S_IDLE;
            S_IDLE:   if (req_valid) state_ff <= S_HASH;
            S_HASH:   state_ff <= S_READ;
            S_READ:   state_ff <= S_UPDATE;
            S_UPDATE: if (!stat.out_busy) state_ff <= S_IDLE;
            default:  state_ff <= S_CLEAR;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_commit_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.clr_write))
      else $error("write-back during clearing sweep");

   a_accept_then_id: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.load_id)
      else $error("accepted beat not followed by id stage");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.out_busy)
      else $error("result register overwritten");

   a_read_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_read |=> (state_ff == S_UPDATE))
      else $error("table read not followed by update");
`endif

endmodule

### hdl/tcct_datapath.sv
// ----------------------------------------------------------------------------
// tcct_datapath: id, connection table and result register
// Holds the request beat, forms the connection id, reads and rewrites one
// table entry and keeps the result beat until it is taken.
// ----------------------------------------------------------------------------
module tcct_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tcct_pkg::ctrl_cmd_type            cmd,
   output tcct_pkg::ctrl_stat_type           stat,
   input  logic                              req_mode,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_src_addr,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_dst_addr,
   input  logic [tcct_pkg::PROTO_W-1:0]      req_protocol,
   input  logic [tcct_pkg::PORT_W-1:0]       req_src_port,
   input  logic [tcct_pkg::PORT_W-1:0]       req_dst_port,
   input  logic                              req_syn_flag,
   input  logic                              req_ack_flag,
   input  logic                              req_fin_flag,
   input  logic [tcct_pkg::COOKIE_W-1:0]     req_acc_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcct_pkg::ID_W-1:0]         rsp_conn_id,
   output logic                              rsp_is_initial,
   output logic [tcct_pkg::HALF_W-1:0]       rsp_vip_low,
   output logic [tcct_pkg::COOKIE_W-1:0]     rsp_cookie_out,
   output logic                              rsp_closed,
   output logic                              rsp_entry_active
);
   import tcct_pkg::*;

   // captured request
   logic                 mode_ff, syn_ff, ack_ff, fin_ff;
   logic [ADDR_W-1:0]    src_addr_ff, dst_addr_ff;
   logic [PROTO_W-1:0]   protocol_ff;
   logic [PORT_W-1:0]    src_port_ff, dst_port_ff;
   cookie_type           acc_ff;

   id_type               id_ff, id_in;
   idx_type              clr_idx_ff;
   entry_type            entry_mem [TABLE_ENTRIES];
   entry_type            rd_ff;

   entry_type            new_entry;
   logic                 initial_in, closed_in;
   logic [HALF_W-1:0]    vip_in;
   cookie_type           cookie_in;

   logic                 rsp_valid_ff;
   id_type               conn_id_ff;
   logic                 is_initial_ff, closed_ff, active_ff;
   logic [HALF_W-1:0]    vip_ff;
   cookie_type           cookie_ff;

   idx_type              slot;
   logic                 mem_we;
   idx_type              mem_waddr;
   entry_type            mem_wdata;

   // 16-bit wrapping sum of the address halves, protocol and ports, then inverted
   always_comb begin
      id_in = src_addr_ff[HALF_W-1:0] + src_addr_ff[ADDR_W-1:HALF_W]
            + dst_addr_ff[HALF_W-1:0] + dst_addr_ff[ADDR_W-1:HALF_W]
            + {{(ID_W-PROTO_W){1'b0}}, protocol_ff}
            + src_port_ff + dst_port_ff;
      id_in = ~id_in;
   end

   assign slot = id_ff[IDX_W-1:0];

   // entry update
   always_comb begin
      new_entry  = rd_ff;
      initial_in = 1'b0;
      closed_in  = 1'b0;
      vip_in     = '0;
      cookie_in  = '0;
      if (!mode_ff) begin
         if (syn_ff && !ack_ff) begin
            new_entry  = '{active: 1'b1, closing: 1'b0, cookie: '0};
            initial_in = 1'b1;
            vip_in     = dst_addr_ff[HALF_W-1:0];
         end else begin
            cookie_in = rd_ff.cookie;
         end
         if (fin_ff) new_entry.closing = 1'b1;
      end else begin
         priority if (syn_ff) begin
            new_entry.active = 1'b1;
            new_entry.cookie = acc_ff;
         end else if (ack_ff && rd_ff.closing) begin
            new_entry = ENTRY_EMPTY;
            closed_in = 1'b1;
         end else begin
            new_entry = rd_ff;   // other incoming beats leave the entry as is
         end
      end
   end

   assign mem_we    = cmd.clr_write || cmd.commit;
   assign mem_waddr = cmd.clr_write ? clr_idx_ff : slot;
   assign mem_wdata = cmd.clr_write ? ENTRY_EMPTY : new_entry;

   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_read) rd_ff <= entry_mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff     <= req_mode;
         src_addr_ff <= req_src_addr;
         dst_addr_ff <= req_dst_addr;
         protocol_ff <= req_protocol;
         src_port_ff <= req_src_port;
         dst_port_ff <= req_dst_port;
         syn_ff      <= req_syn_flag;
         ack_ff      <= req_ack_flag;
         fin_ff      <= req_fin_flag;
         acc_ff      <= req_acc_value;
      end
      if (cmd.load_id) id_ff <= id_in;
      if (cmd.commit) begin
         conn_id_ff    <= id_ff;
         is_initial_ff <= initial_in;
         vip_ff        <= vip_in;
         cookie_ff     <= cookie_in;
         closed_ff     <= closed_in;
         active_ff     <= new_entry.active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.clr_last = (clr_idx_ff == idx_type'(TABLE_ENTRIES - 1));
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_conn_id      = conn_id_ff;
   assign rsp_is_initial   = is_initial_ff;
   assign rsp_vip_low      = vip_ff;
   assign rsp_cookie_out   = cookie_ff;
   assign rsp_closed       = closed_ff;
   assign rsp_entry_active = active_ff;

endmodule

### hdl/tcp_connection_cookie_tracker_top.sv
// ----------------------------------------------------------------------------
// tcp_connection_cookie_tracker_top: load balancer connection cookie tracker
// Forms a 16-bit connection id per TCP segment and keeps active mark,
// closing mark and cookie per id in an on-chip table.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------------
//   req      req_valid / req_ready  mode, addresses, protocol, ports, flags,
//                                   acc_value (one segment per beat)
//   rsp      rsp_valid / rsp_ready  conn_id, is_initial, vip_low,
//                                   cookie_out, closed, entry_active
//
// Sequence: each segment steps through capture, id sum, table read and
//   write-back; one segment is in flight at a time. The result beat is
//   offered once write-back loads the result register, and the next req beat
//   can be taken in the idle state that follows.
// Reset: synchronous. Afterwards the table is swept to zero, one entry per
//   cycle, over all TABLE_ENTRIES entries; req_ready stays low meanwhile.
// Stalls: the result register frees the input side, so the next beat is
//   taken while a result waits; write-back holds only if that result is
//   still untaken.
//
module tcp_connection_cookie_tracker_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_src_addr,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_dst_addr,
   input  logic [tcct_pkg::PROTO_W-1:0]      req_protocol,
   input  logic [tcct_pkg::PORT_W-1:0]       req_src_port,
   input  logic [tcct_pkg::PORT_W-1:0]       req_dst_port,
   input  logic                              req_syn_flag,
   input  logic                              req_ack_flag,
   input  logic                              req_fin_flag,
   input  logic [tcct_pkg::COOKIE_W-1:0]     req_acc_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcct_pkg::ID_W-1:0]         rsp_conn_id,
   output logic                              rsp_is_initial,
   output logic [tcct_pkg::HALF_W-1:0]       rsp_vip_low,
   output logic [tcct_pkg::COOKIE_W-1:0]     rsp_cookie_out,
   output logic                              rsp_closed,
   output logic                              rsp_entry_active
);
   import tcct_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer: sweep, then capture -> id -> read -> write-back
   tcct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // id adder, table memory, entry update and result register
   tcct_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_protocol     (req_protocol),
      .req_src_port     (req_src_port),
      .req_dst_port     (req_dst_port),
      .req_syn_flag     (req_syn_flag),
      .req_ack_flag     (req_ack_flag),
      .req_fin_flag     (req_fin_flag),
      .req_acc_value    (req_acc_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_conn_id      (rsp_conn_id),
      .rsp_is_initial   (rsp_is_initial),
      .rsp_vip_low      (rsp_vip_low),
      .rsp_cookie_out   (rsp_cookie_out),
      .rsp_closed       (rsp_closed),
      .rsp_entry_active (rsp_entry_active)
   );

endmodule

### verif/tcct_checker.sv
// ----------------------------------------------------------------------------
// tcct_checker: scoreboard for the connection cookie tracker
// Watches the req and rsp channels, keeps its own copy of the connection
// table, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
package tcct_tb_pkg;

   typedef enum logic {
      DIR_OUT = 1'b0,   // segment from the tunnel
      DIR_IN  = 1'b1    // segment from the switch
   } dir_type;

   typedef struct packed {
      logic [tcct_pkg::ADDR_W-1:0]  src_addr;
      logic [tcct_pkg::ADDR_W-1:0]  dst_addr;
      logic [tcct_pkg::PROTO_W-1:0] protocol;
      logic [tcct_pkg::PORT_W-1:0]  src_port;
      logic [tcct_pkg::PORT_W-1:0]  dst_port;
   } tuple_type;

   typedef struct packed {
      dir_type              mode;
      tuple_type            conn;
      logic                 syn;
      logic                 ack;
      logic                 fin;
      tcct_pkg::cookie_type acc;
   } seg_type;

   typedef struct packed {
      tcct_pkg::id_type            conn_id;
      logic                        is_init;
      logic [tcct_pkg::HALF_W-1:0] vip;
      tcct_pkg::cookie_type        cookie;
      logic                        closed;
      logic                        active;
   } result_type;

endpackage

module tcct_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_mode,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_src_addr,
   input  logic [tcct_pkg::ADDR_W-1:0]       req_dst_addr,
   input  logic [tcct_pkg::PROTO_W-1:0]      req_protocol,
   input  logic [tcct_pkg::PORT_W-1:0]       req_src_port,
   input  logic [tcct_pkg::PORT_W-1:0]       req_dst_port,
   input  logic                              req_syn_flag,
   input  logic                              req_ack_flag,
   input  logic                              req_fin_flag,
   input  logic [tcct_pkg::COOKIE_W-1:0]     req_acc_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [tcct_pkg::ID_W-1:0]         rsp_conn_id,
   input  logic                              rsp_is_initial,
   input  logic [tcct_pkg::HALF_W-1:0]       rsp_vip_low,
   input  logic [tcct_pkg::COOKIE_W-1:0]     rsp_cookie_out,
   input  logic                              rsp_closed,
   input  logic                              rsp_entry_active,
   output int                                fail_count,
   output int                                outstanding
);
   import tcct_pkg::*;
   import tcct_tb_pkg::*;

   logic       open_mark    [TABLE_ENTRIES];
   logic       fin_mark     [TABLE_ENTRIES];
   cookie_type cookie_store [TABLE_ENTRIES];

   result_type pending_results [$];
   int         errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // inverted 16-bit wrap-around sum over address halves, protocol, ports
   function automatic id_type conn_hash(tuple_type t);
      id_type sum;
      sum = t.src_addr[HALF_W-1:0] + t.src_addr[ADDR_W-1:HALF_W]
          + t.dst_addr[HALF_W-1:0] + t.dst_addr[ADDR_W-1:HALF_W]
          + id_type'(t.protocol) + t.src_port + t.dst_port;
      return ~sum;
   endfunction

   // apply one segment to the table copy and return the result beat
   function automatic result_type predict_segment(seg_type s);
      result_type r;
      int         slot;
      r         = '0;
      r.conn_id = conn_hash(s.conn);
      slot      = int'(r.conn_id) % TABLE_ENTRIES;
      if (s.mode == DIR_OUT) begin
         if (s.syn && !s.ack) begin
            open_mark[slot]    = 1'b1;
            fin_mark[slot]     = 1'b0;
            cookie_store[slot] = '0;
            r.is_init          = 1'b1;
            r.vip              = s.conn.dst_addr[HALF_W-1:0];
         end else begin
            r.cookie = cookie_store[slot];
         end
         if (s.fin)
            fin_mark[slot] = 1'b1;
      end else begin
         if (s.syn) begin
            open_mark[slot]    = 1'b1;
            cookie_store[slot] = s.acc;
         end else if (s.ack && fin_mark[slot]) begin
            open_mark[slot]    = 1'b0;
            fin_mark[slot]     = 1'b0;
            cookie_store[slot] = '0;
            r.closed           = 1'b1;
         end
      end
      r.active = open_mark[slot];
      return r;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      seg_type    seg;
      result_type want;
      if (reset) begin
         open_mark    = '{default: 1'b0};
         fin_mark     = '{default: 1'b0};
         cookie_store = '{default: '0};
         pending_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            seg.mode          = dir_type'(req_mode);
            seg.conn.src_addr = req_src_addr;
            seg.conn.dst_addr = req_dst_addr;
            seg.conn.protocol = req_protocol;
            seg.conn.src_port = req_src_port;
            seg.conn.dst_port = req_dst_port;
            seg.syn           = req_syn_flag;
            seg.ack           = req_ack_flag;
            seg.fin           = req_fin_flag;
            seg.acc           = req_acc_value;
            pending_results.push_back(predict_segment(seg));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none actual id %h",
                        $time, rsp_conn_id);
            end else begin
               want = pending_results.pop_front();
               check_field("conn_id",      32'(want.conn_id), 32'(rsp_conn_id));
               check_field("is_initial",   32'(want.is_init), 32'(rsp_is_initial));
               check_field("vip_low",      32'(want.vip),     32'(rsp_vip_low));
               check_field("cookie_out",   32'(want.cookie),  32'(rsp_cookie_out));
               check_field("closed",       32'(want.closed),  32'(rsp_closed));
               check_field("entry_active", 32'(want.active),  32'(rsp_entry_active));
            end
         end
      end
      outstanding <= pending_results.size();
      fail_count  <= errors;
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top of the connection cookie tracker
// Drives directed and random TCP segment beats with random idle on both
// channels; the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import tcct_pkg::*;
   import tcct_tb_pkg::*;

   localparam int ITEM_TARGET  = 1170;     // directed part plus about 1150 random
   localparam int POOL_SIZE    = 12;       // live connections for lifecycles
   localparam int DRAIN_CYCLES = 16;       // quiet cycles after the last result beat
   localparam int RUN_LIMIT    = 5000000;  // time limit; covers the clear sweep

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_mode         = 1'b0;
   logic [ADDR_W-1:0]   req_src_addr     = '0;
   logic [ADDR_W-1:0]   req_dst_addr     = '0;
   logic [PROTO_W-1:0]  req_protocol     = '0;
   logic [PORT_W-1:0]   req_src_port     = '0;
   logic [PORT_W-1:0]   req_dst_port     = '0;
   logic                req_syn_flag     = 1'b0;
   logic                req_ack_flag     = 1'b0;
   logic                req_fin_flag     = 1'b0;
   logic [COOKIE_W-1:0] req_acc_value    = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [ID_W-1:0]     rsp_conn_id;
   logic                rsp_is_initial;
   logic [HALF_W-1:0]   rsp_vip_low;
   logic [COOKIE_W-1:0] rsp_cookie_out;
   logic                rsp_closed;
   logic                rsp_entry_active;

   int        fail_count;
   int        outstanding;
   int        items_sent = 0;
   logic      steady     = 1'b0;   // no idling on either side while set
   tuple_type pool [POOL_SIZE];

   tcp_connection_cookie_tracker_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_protocol     (req_protocol),
      .req_src_port     (req_src_port),
      .req_dst_port     (req_dst_port),
      .req_syn_flag     (req_syn_flag),
      .req_ack_flag     (req_ack_flag),
      .req_fin_flag     (req_fin_flag),
      .req_acc_value    (req_acc_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_conn_id      (rsp_conn_id),
      .rsp_is_initial   (rsp_is_initial),
      .rsp_vip_low      (rsp_vip_low),
      .rsp_cookie_out   (rsp_cookie_out),
      .rsp_closed       (rsp_closed),
      .rsp_entry_active (rsp_entry_active)
   );

   tcct_checker i_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_protocol     (req_protocol),
      .req_src_port     (req_src_port),
      .req_dst_port     (req_dst_port),
      .req_syn_flag     (req_syn_flag),
      .req_ack_flag     (req_ack_flag),
      .req_fin_flag     (req_fin_flag),
      .req_acc_value    (req_acc_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_conn_id      (rsp_conn_id),
      .rsp_is_initial   (rsp_is_initial),
      .rsp_vip_low      (rsp_vip_low),
      .rsp_cookie_out   (rsp_cookie_out),
      .rsp_closed       (rsp_closed),
      .rsp_entry_active (rsp_entry_active),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // sync reset, released on a falling edge
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
   end

   // rsp side back-pressure: ready low about a quarter of the cycles, except while steady
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 25);
   end

   initial begin
      #(RUN_LIMIT);
      $display("[tcp_connection_cookie_tracker_top] ERROR");
      $finish;
   end

   function automatic tuple_type rand_tuple();
      tuple_type t;
      t.src_addr = $urandom;
      t.dst_addr = $urandom;
      t.protocol = PROTO_W'($urandom);
      t.src_port = PORT_W'($urandom);
      t.dst_port = PORT_W'($urandom);
      return t;
   endfunction

   function automatic seg_type make_seg(dir_type d, tuple_type t, logic syn, logic ack,
                                        logic fin, cookie_type acc);
      seg_type s;
      s.mode = d;
      s.conn = t;
      s.syn  = syn;
      s.ack  = ack;
      s.fin  = fin;
      s.acc  = acc;
      return s;
   endfunction

   function automatic cookie_type rand_cookie();
      return COOKIE_W'($urandom);
   endfunction

   // present one beat, with random idle ahead of it, and wait for acceptance
   task automatic send_seg(seg_type s);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 25) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_mode      <= s.mode;
      req_src_addr  <= s.conn.src_addr;
      req_dst_addr  <= s.conn.dst_addr;
      req_protocol  <= s.conn.protocol;
      req_src_port  <= s.conn.src_port;
      req_dst_port  <= s.conn.dst_port;
      req_syn_flag  <= s.syn;
      req_ack_flag  <= s.ack;
      req_fin_flag  <= s.fin;
      req_acc_value <= s.acc;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic keep_step();
      return $urandom_range(99) < 88;
   endfunction

   // open, switch SYN, data, FIN, data, switch ACK; steps drop out now and then
   task automatic run_lifecycle(tuple_type t);
      if (keep_step()) send_seg(make_seg(DIR_OUT, t, 1'b1, 1'b0, 1'b0, rand_cookie()));
      if (keep_step())
         send_seg(make_seg(DIR_IN, t, 1'b1, 1'($urandom_range(1)), 1'b0, rand_cookie()));
      repeat ($urandom_range(3))
         send_seg(make_seg(DIR_OUT, t, 1'b0, 1'b1, 1'b0, rand_cookie()));
      if (keep_step()) send_seg(make_seg(DIR_OUT, t, 1'b0, 1'b1, 1'b1, rand_cookie()));
      if (keep_step()) send_seg(make_seg(DIR_OUT, t, 1'b0, 1'b1, 1'b0, rand_cookie()));
      if (keep_step())
         send_seg(make_seg(DIR_IN, t, 1'b0, 1'b1, 1'($urandom_range(1)), rand_cookie()));
   endtask

   initial begin
      tuple_type t_zero;
      tuple_type t_ones;
      tuple_type t_a;
      tuple_type t_swap;
      tuple_type t_new;
      int        pick;
      int        n;

      t_zero = '0;
      t_ones = '1;
      t_a    = rand_tuple();
      // same sum with the ports and source address halves swapped: a second connection on the same entry
      t_swap          = t_a;
      t_swap.src_port = t_a.dst_port;
      t_swap.dst_port = t_a.src_port;
      t_swap.src_addr = {t_a.src_addr[HALF_W-1:0], t_a.src_addr[ADDR_W-1:HALF_W]};
      foreach (pool[i]) pool[i] = rand_tuple();

      // ---- directed part ----
      // entry never opened reads as zero; acc_value ignored on outgoing
      send_seg(make_seg(DIR_OUT, t_zero, 1'b0, 1'b1, 1'b0, 16'hFFFF));
      send_seg(make_seg(DIR_IN,  t_zero, 1'b0, 1'b1, 1'b1, 16'hFFFF));
      // all-ones tuple: full open / cookie / close sequence
      send_seg(make_seg(DIR_OUT, t_ones, 1'b1, 1'b0, 1'b0, 16'hFFFF));
      send_seg(make_seg(DIR_IN,  t_ones, 1'b1, 1'b1, 1'b0, 16'hFFFF));
      send_seg(make_seg(DIR_OUT, t_ones, 1'b0, 1'b1, 1'b0, 16'h0000));
      send_seg(make_seg(DIR_OUT, t_ones, 1'b0, 1'b1, 1'b1, 16'h0000));
      send_seg(make_seg(DIR_IN,  t_ones, 1'b0, 1'b0, 1'b1, 16'h1234));  // FIN alone: no effect
      send_seg(make_seg(DIR_IN,  t_ones, 1'b0, 1'b1, 1'b0, 16'h0000));  // closes
      send_seg(make_seg(DIR_IN,  t_ones, 1'b0, 1'b1, 1'b0, 16'h0000));  // no longer closing
      send_seg(make_seg(DIR_OUT, t_ones, 1'b0, 1'b1, 1'b0, 16'hFFFF));
      // SYN without ACK that also carries FIN opens and marks closing
      send_seg(make_seg(DIR_OUT, t_a, 1'b1, 1'b0, 1'b1, rand_cookie()));
      send_seg(make_seg(DIR_IN,  t_a, 1'b1, 1'b1, 1'b0, rand_cookie()));  // keeps closing
      send_seg(make_seg(DIR_OUT, t_a, 1'b1, 1'b1, 1'b0, rand_cookie()));  // SYN+ACK: not initial
      send_seg(make_seg(DIR_IN,  t_a, 1'b0, 1'b1, 1'b0, rand_cookie()));
      // colliding connections share one entry
      send_seg(make_seg(DIR_OUT, t_a,    1'b1, 1'b0, 1'b0, rand_cookie()));
      send_seg(make_seg(DIR_IN,  t_swap, 1'b1, 1'b0, 1'b0, rand_cookie()));
      send_seg(make_seg(DIR_OUT, t_a,    1'b0, 1'b1, 1'b0, rand_cookie()));
      // incoming SYN on an entry never opened, then flag-less beats and one beat with all flags
      send_seg(make_seg(DIR_IN,  t_zero, 1'b1, 1'b0, 1'b0, 16'h0000));
      send_seg(make_seg(DIR_IN,  t_zero, 1'b0, 1'b0, 1'b0, 16'hFFFF));
      send_seg(make_seg(DIR_OUT, t_zero, 1'b0, 1'b0, 1'b0, 16'h0000));
      send_seg(make_seg(DIR_OUT, t_a,    1'b1, 1'b1, 1'b1, rand_cookie()));

      // ---- random part ----
      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= 450) && (items_sent < 750);
         pick   = $urandom_range(99);
         n      = $urandom_range(POOL_SIZE - 1);
         if (pick < 65) begin
            run_lifecycle(pool[n]);
         end else if (pick < 90) begin
            send_seg(make_seg(dir_type'($urandom_range(1)), pool[n], 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)), rand_cookie()));
         end else begin
            send_seg(make_seg(dir_type'($urandom_range(1)), rand_tuple(),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), rand_cookie()));
         end
         // refresh a pool slot now and then, sometimes with a colliding tuple
         if ($urandom_range(29) == 0) begin
            t_new = pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(1) == 0) begin
               t_new = rand_tuple();
            end else begin
               {t_new.src_port, t_new.dst_port} = {t_new.dst_port, t_new.src_port};
               t_new.protocol = t_new.protocol;
            end
            pool[$urandom_range(POOL_SIZE - 1)] = t_new;
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: every expected beat back, then a few quiet cycles
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("[tcp_connection_cookie_tracker_top] OK");
      end else begin
         $display("[tcp_connection_cookie_tracker_top] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hdl/tcct_pkg.sv
hdl/tcct_ctrl.sv
hdl/tcct_datapath.sv
hdl/tcp_connection_cookie_tracker_top.sv
verif/tcct_checker.sv
verif/tb.sv
